### rtl/rlet_pkg.sv
// Shared types and codes for the route lookup block.
package rlet_pkg;

  localparam int unsigned ADDR_W = 32;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] if_index;
    logic [ADDR_W-1:0] metric;
    logic [ADDR_W-1:0] next_hop;
    logic              valid;
  } rlet_entry_t;

  localparam int unsigned ENTRY_W = $bits(rlet_entry_t);

  // Best route found so far during a scan.
  typedef struct packed {
    logic              have;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] metric;
    logic [ADDR_W-1:0] if_index;
    logic [ADDR_W-1:0] next_hop;
  } rlet_best_t;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TUNNEL_IF   = 1'b0,
    REG_ENTRY_COUNT = 1'b1
  } rlet_reg_e;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SLOT_W  = 6;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } rlet_state_e;

endpackage

### rtl/route_lookup_excluding_tunnel_top.sv
// Route table with a sequential largest-masked-prefix lookup that skips the tunnel interface.
// Write: no result; busy_o stays low, so the next item can follow at once.
// Lookup, n = entry_count capped at ROUTE_ENTRIES, one entry per cycle through one compare:
//   done_o rises once the last entry is read and compared; busy_o is high meanwhile.
// With n = 0 done_o rises at the transfer edge itself; the receiver cannot stall results.
// Reset clears control state and the registers (tunnel 0xFFFFFFFF, count 0); table undefined.
module route_lookup_excluding_tunnel_top
  import rlet_pkg::*;
#(
  parameter int unsigned ROUTE_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 req_type_i,
  input  logic [SLOT_W-1:0]    entry_slot_i,
  input  logic [ADDR_W-1:0]    route_dest_i,
  input  logic [ADDR_W-1:0]    route_mask_i,
  input  logic [ADDR_W-1:0]    route_if_i,
  input  logic [ADDR_W-1:0]    route_metric_i,
  input  logic [ADDR_W-1:0]    route_next_hop_i,
  input  logic                 route_valid_i,
  input  logic [ADDR_W-1:0]    lookup_dest_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [ADDR_W-1:0]    out_if_index_o,
  output logic [ADDR_W-1:0]    out_next_hop_o
);

  localparam int unsigned IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  rlet_state_e state_q, state_d;

  logic [ADDR_W-1:0]  tunnel_if_q;
  logic [COUNT_W-1:0] entry_count_q;

  logic [ENTRY_W-1:0] table_mem [ROUTE_ENTRIES];
  rlet_entry_t        wr_entry;
  rlet_entry_t        rd_entry;
  logic [ENTRY_W-1:0] rdata_q;

  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [IDX_W-1:0]   last_q, last_d;
  logic               rvld_q, rvld_d;
  logic               rlast_q, rlast_d;
  logic [ADDR_W-1:0]  dest_q, dest_d;
  rlet_best_t         best_q, best_d, best_cmp;

  logic               accept;
  logic               wr_en;
  logic               lookup;
  logic               count_zero;
  logic [31:0]        count_cap;
  logic               done_d;

  assign accept  = start_i && !busy_o;
  assign lookup  = accept && (req_type_i == REQ_LOOKUP);
  assign wr_en   = accept && (req_type_i == REQ_WRITE) &&
                   (32'(entry_slot_i) < 32'(ROUTE_ENTRIES));
  assign busy_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign count_zero = (entry_count_q == '0);
  assign count_cap  = (32'(entry_count_q) > 32'(ROUTE_ENTRIES)) ? 32'(ROUTE_ENTRIES)
                                                                : 32'(entry_count_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tunnel_if_q   <= ALL_ONES;
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TUNNEL_IF:   tunnel_if_q   <= cfg_data_i;
        REG_ENTRY_COUNT: entry_count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Route table
  always_comb begin
    wr_entry.dest     = route_dest_i;
    wr_entry.mask     = route_mask_i;
    wr_entry.if_index = route_if_i;
    wr_entry.metric   = route_metric_i;
    wr_entry.next_hop = route_next_hop_i;
    wr_entry.valid    = route_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[IDX_W'(entry_slot_i)] <= wr_entry;
    end
    rdata_q <= table_mem[addr_q];
  end

  assign rd_entry = rlet_entry_t'(rdata_q);

  rlet_cmp u_cmp (
    .entry_i       (rd_entry),
    .lookup_dest_i (dest_q),
    .tunnel_if_i   (tunnel_if_q),
    .best_i        (best_q),
    .best_o        (best_cmp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    last_d  = last_q;
    dest_d  = dest_q;
    best_d  = best_q;
    rvld_d  = 1'b0;
    rlast_d = 1'b0;
    done_d  = 1'b0;

    if (rvld_q) begin
      best_d = best_cmp;
    end

    case (state_q)
      ST_IDLE: begin
        if (lookup) begin
          dest_d          = lookup_dest_i;
          best_d.have     = 1'b0;
          best_d.prefix   = '0;
          best_d.metric   = ALL_ONES;
          best_d.if_index = '0;
          best_d.next_hop = '0;
          addr_d          = '0;
          last_d          = IDX_W'(count_cap - 32'd1);
          if (count_zero) begin
            done_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rvld_d  = 1'b1;
        rlast_d = (addr_q == last_q);
        addr_d  = addr_q + IDX_W'(1);
        if (addr_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (rvld_q && rlast_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rvld_q  <= 1'b0;
      rlast_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rvld_d;
      rlast_q <= rlast_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    last_q <= last_d;
    dest_q <= dest_d;
    best_q <= best_d;
    if (done_d) begin
      found_o        <= best_d.have;
      out_if_index_o <= best_d.have ? best_d.if_index : '0;
      out_next_hop_o <= best_d.have ? best_d.next_hop : '0;
    end
  end

  // Checks
  a_rvld_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> $past(state_q == ST_SCAN))
    else $error("read data marked valid without a scan read");

  a_no_route_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (out_if_index_o == '0 && out_next_hop_o == '0))
    else $error("empty result carries nonzero route fields");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lookup && !count_zero) |=> (busy_o && !done_o))
    else $error("lookup over a nonempty table did not start a scan");

  a_done_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(busy_o)) |-> $past(state_q == ST_DRAIN && rlast_q))
    else $error("result issued before the last entry was compared");

endmodule

### rtl/rlet_cmp.sv
// Per-entry match and preference compare, shared across the whole scan.
module rlet_cmp
  import rlet_pkg::*;
(
  input  rlet_entry_t       entry_i,
  input  logic [ADDR_W-1:0] lookup_dest_i,
  input  logic [ADDR_W-1:0] tunnel_if_i,
  input  rlet_best_t        best_i,
  output rlet_best_t        best_o
);

  logic [ADDR_W-1:0] prefix;
  logic              match;
  logic              better;

  assign prefix = lookup_dest_i & entry_i.mask;
  assign match  = entry_i.valid && (entry_i.if_index != tunnel_if_i) &&
                  ((entry_i.dest & entry_i.mask) == prefix);
  // Larger masked value wins; on a tie only a strictly lower metric replaces.
  assign better = (prefix > best_i.prefix) ||
                  ((prefix == best_i.prefix) && (entry_i.metric < best_i.metric));

  always_comb begin
    best_o = best_i;
    if (match && better) begin
      best_o.have     = 1'b1;
      best_o.prefix   = prefix;
      best_o.metric   = entry_i.metric;
      best_o.if_index = entry_i.if_index;
      best_o.next_hop = entry_i.next_hop;
    end
  end

endmodule
